FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SLT_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that one condition implies another on the next edge.
`define SLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/slt_pkg.sv
// Package: types, constants and register indexes of the local threshold block.
package slt_pkg;

    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_MAX_ROWS   = 128;
    localparam int DEF_MAX_RADIUS = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_DW         = 9;
    localparam int CFG_IW         = 2;

    localparam logic [CFG_IW-1:0] REG_IMAGE_COLS    = 2'd0;
    localparam logic [CFG_IW-1:0] REG_IMAGE_ROWS    = 2'd1;
    localparam logic [CFG_IW-1:0] REG_WINDOW_RADIUS = 2'd2;
    localparam logic [CFG_IW-1:0] REG_K_GAIN        = 2'd3;

    localparam logic [8:0] RST_IMAGE_COLS    = 9'd256;
    localparam logic [7:0] RST_IMAGE_ROWS    = 8'd128;
    localparam logic [4:0] RST_WINDOW_RADIUS = 5'd8;
    localparam logic [4:0] RST_K_GAIN        = 5'd0;

    localparam logic KIND_WRITE    = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [6:0] row;
        logic [7:0] col;
        logic [7:0] pixel_value;
    } in_t;

    typedef struct packed {
        logic [7:0] threshold;
        logic       is_foreground;
        logic [6:0] out_row;
        logic [7:0] out_col;
    } out_t;

    typedef struct packed {
        logic [8:0]        image_cols;
        logic [7:0]        image_rows;
        logic [4:0]        window_radius;
        logic signed [4:0] k_gain;
    } cfg_t;

endpackage

FILE: rtl/slt_ram.sv
// Generic single-port RAM with registered read.
module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/slt_front.sv
// Front end: accepts command words and queues them for the back end.
`include "assert_macros.svh"
module slt_front import slt_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  in_t  cmd,
    output logic busy,
    input  logic pop,
    output logic head_valid,
    output in_t  head
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    in_t             q_reg [DEPTH];
    logic [PTRW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            push;

    assign busy       = (cnt_reg == CNTW'(DEPTH));
    assign push       = start && !busy;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CNTW'(push) - CNTW'(pop);
        end
    end

    `SLT_ASSERT(a_cnt_bound, cnt_reg <= CNTW'(DEPTH), "queue count above depth")
    `SLT_ASSERT(a_pop_nonempty, !pop || head_valid, "pop from empty queue")

endmodule

FILE: rtl/slt_div.sv
// Restoring serial divider, one quotient bit per cycle.
module slt_div #(
    parameter int DW = 51,
    parameter int VW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quot,
    output logic          rem_nz,
    output logic          done
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quot_reg;
    logic [VW-1:0] rem_reg, dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic          fits;

    assign trial  = {rem_reg, quot_reg[DW-1]};
    assign fits   = (trial >= {1'b0, dvs_reg});
    assign quot   = quot_reg;
    assign rem_nz = (rem_reg != '0);
    assign done   = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= fits ? VW'(trial - {1'b0, dvs_reg}) : VW'(trial);
            quot_reg <= {quot_reg[DW-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg <= CW'(DW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/slt_sqrt.sv
// Serial integer square root, one root bit per cycle.
module slt_sqrt #(
    parameter int QW = 52
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [QW-1:0]     radicand,
    output logic [QW/2-1:0]   root,
    output logic              rem_nz,
    output logic              done
);

    localparam int RTW = QW / 2;
    localparam int RW  = RTW + 2;
    localparam int CW  = $clog2(RTW + 1);

    logic [QW-1:0]  x_reg;
    logic [RTW-1:0] root_reg;
    logic [RW-1:0]  rem_reg;
    logic [CW-1:0]  cnt_reg;
    logic           done_reg;
    logic [RW+1:0]  sh, trial;
    logic           fits;

    assign sh     = {rem_reg, x_reg[QW-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = (sh >= trial);
    assign root   = root_reg;
    assign rem_nz = (rem_reg != '0);
    assign done   = done_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            x_reg    <= {x_reg[QW-3:0], 2'b00};
            rem_reg  <= fits ? RW'(sh - trial) : RW'(sh);
            root_reg <= {root_reg[RTW-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg <= CW'(RTW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/slt_back.sv
// Back end: frame store, window passes and threshold arithmetic.
`include "assert_macros.svh"
module slt_back import slt_pkg::*; #(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic head_valid,
    input  in_t  head,
    output logic pop,
    output logic done,
    output out_t result
);

    localparam int PW    = $clog2(MAX_COLS + MAX_ROWS + MAX_RADIUS + 256);
    localparam int AW    = $clog2(MAX_ROWS * MAX_COLS);
    localparam int NW    = $clog2((2 * MAX_RADIUS) * (2 * MAX_RADIUS) + 1);
    localparam int SUMW  = NW + 8;
    localparam int ACCW  = NW + 16;
    localparam int ACCHW = ACCW - 16;
    localparam int PAW   = 12;
    localparam int PA2W  = 2 * PAW;
    localparam int PLW   = PA2W + 16;
    localparam int HIW   = PA2W + ACCHW;
    localparam int NUMW  = PA2W + ACCW;
    localparam int QW    = NUMW + (NUMW % 2);
    localparam int RTW   = QW / 2;
    localparam int YW    = RTW + 3;
    localparam int MKW   = 15;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CTR    = 4'd1;
    localparam logic [3:0] S_PASS   = 4'd2;
    localparam logic [3:0] S_DRAIN  = 4'd3;
    localparam logic [3:0] S_MDIV   = 4'd4;
    localparam logic [3:0] S_MWAIT  = 4'd5;
    localparam logic [3:0] S_PM     = 4'd6;
    localparam logic [3:0] S_SQ     = 4'd7;
    localparam logic [3:0] S_MLO    = 4'd8;
    localparam logic [3:0] S_MHI    = 4'd9;
    localparam logic [3:0] S_QDIV   = 4'd10;
    localparam logic [3:0] S_QWAIT  = 4'd11;
    localparam logic [3:0] S_RT     = 4'd12;
    localparam logic [3:0] S_RTWAIT = 4'd13;
    localparam logic [3:0] S_FIN    = 4'd14;
    localparam logic [3:0] S_OUT    = 4'd15;

    function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] r, input logic [PW-1:0] c);
        addr_of = AW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    logic [3:0]         state_reg;
    logic [6:0]         row_reg;
    logic [7:0]         col_reg;
    logic               in_store_reg;
    logic [PW-1:0]      r0_reg, r1_reg, c0_reg, c1_reg, r_reg, c_reg;
    logic               empty_reg, pass_reg, rd_valid_reg;
    logic [7:0]         pix_reg, m_reg;
    logic [NW-1:0]      n_reg;
    logic [SUMW-1:0]    sum_reg;
    logic [ACCW-1:0]    acc_reg;
    logic [PAW-1:0]     pa_reg;
    logic [PA2W-1:0]    pa2_reg;
    logic [NUMW-1:0]    num_reg;
    logic signed [MKW-1:0] mk_reg;
    logic               pneg_reg, use_root_reg, qrem_reg, srem_reg;
    logic [RTW-1:0]     sq_reg;
    logic signed [YW-1:0] y_reg;
    logic               done_reg;
    out_t               result_reg;

    logic [PW-1:0]      rad, rows_c, cols_c, hrow, hcol, r0_h, r1_h, c0_h, c1_h;
    logic               h_in_store;
    logic [AW-1:0]      ram_addr;
    logic               ram_we;
    logic [7:0]         ram_dout, d;
    logic               div_start, div_done, div_rem_nz;
    logic [NUMW-1:0]    div_dividend, div_quot;
    logic [NW-1:0]      div_divisor;
    logic               rt_start, rt_done, rt_rem_nz;
    logic [RTW-1:0]     rt_root;
    logic [4:0]         kabs;
    logic signed [5:0]  omk;
    logic signed [YW-1:0] adj, y_sh;
    logic               last_c, last_r;

    // Window bounds of the queued item, clipped to the frame in use.
    assign rad    = (32'(cfg.window_radius) < MAX_RADIUS) ? PW'(cfg.window_radius)
                                                          : PW'(MAX_RADIUS);
    assign rows_c = (32'(cfg.image_rows) < MAX_ROWS) ? PW'(cfg.image_rows) : PW'(MAX_ROWS);
    assign cols_c = (32'(cfg.image_cols) < MAX_COLS) ? PW'(cfg.image_cols) : PW'(MAX_COLS);
    assign hrow   = PW'(head.row);
    assign hcol   = PW'(head.col);
    assign r0_h   = (hrow >= rad) ? hrow - rad : '0;
    assign c0_h   = (hcol >= rad) ? hcol - rad : '0;
    assign r1_h   = (hrow + rad < rows_c) ? hrow + rad : rows_c;
    assign c1_h   = (hcol + rad < cols_c) ? hcol + rad : cols_c;
    assign h_in_store = (32'(head.row) < MAX_ROWS) && (32'(head.col) < MAX_COLS);

    assign pop      = (state_reg == S_IDLE) && head_valid;
    assign ram_we   = pop && (head.kind == KIND_WRITE) && h_in_store;
    assign ram_addr = (state_reg == S_IDLE) ? addr_of(hrow, hcol) : addr_of(r_reg, c_reg);

    slt_ram #(.WIDTH(8), .DEPTH(MAX_ROWS * MAX_COLS)) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head.pixel_value),
        .rdata (ram_dout)
    );

    assign div_start    = (state_reg == S_MDIV) || (state_reg == S_QDIV);
    assign div_dividend = (state_reg == S_MDIV) ? NUMW'(sum_reg) : num_reg;
    assign div_divisor  = (state_reg == S_MDIV) ? n_reg : n_reg - 1'b1;

    slt_div #(.DW(NUMW), .VW(NW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .rem_nz   (div_rem_nz),
        .done     (div_done)
    );

    assign rt_start = (state_reg == S_RT);

    slt_sqrt #(.QW(QW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .radicand (QW'(div_quot)),
        .root     (rt_root),
        .rem_nz   (rt_rem_nz),
        .done     (rt_done)
    );

    assign d      = (ram_dout >= m_reg) ? ram_dout - m_reg : m_reg - ram_dout;
    assign kabs   = cfg.k_gain[4] ? 5'(-cfg.k_gain) : 5'(cfg.k_gain);
    assign omk    = 6'sd1 - 6'(cfg.k_gain);
    assign last_c = (c_reg == c1_reg - 1'b1);
    assign last_r = (r_reg == r1_reg - 1'b1);
    assign adj    = !use_root_reg ? '0 :
                    pneg_reg ? -$signed(YW'({1'b0, sq_reg}) + YW'(qrem_reg || srem_reg))
                             : $signed(YW'({1'b0, sq_reg}));
    assign y_sh   = y_reg >>> 7;

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            if (pass_reg)
            begin
                acc_reg <= acc_reg + ACCW'(16'(d) * 16'(d));
            end
            else
            begin
                sum_reg <= sum_reg + SUMW'(ram_dout);
            end
        end
        case (state_reg)
            S_IDLE:
            begin
                row_reg      <= head.row;
                col_reg      <= head.col;
                in_store_reg <= h_in_store;
                r0_reg       <= r0_h;
                r1_reg       <= r1_h;
                c0_reg       <= c0_h;
                c1_reg       <= c1_h;
                empty_reg    <= (r0_h >= r1_h) || (c0_h >= c1_h);
            end
            S_CTR:
            begin
                pix_reg      <= in_store_reg ? ram_dout : 8'd0;
                n_reg        <= NW'(r1_reg - r0_reg) * NW'(c1_reg - c0_reg);
                sum_reg      <= '0;
                r_reg        <= r0_reg;
                c_reg        <= c0_reg;
                mk_reg       <= '0;
                use_root_reg <= 1'b0;
            end
            S_PASS:
            begin
                if (last_c)
                begin
                    c_reg <= c0_reg;
                    r_reg <= r_reg + 1'b1;
                end
                else
                begin
                    c_reg <= c_reg + 1'b1;
                end
            end
            S_MWAIT:
            begin
                m_reg   <= div_quot[7:0];
                acc_reg <= '0;
                r_reg   <= r0_reg;
                c_reg   <= c0_reg;
            end
            S_PM:
            begin
                pa_reg       <= PAW'(m_reg) * PAW'(kabs);
                mk_reg       <= MKW'($signed({1'b0, m_reg})) * MKW'(omk);
                pneg_reg     <= cfg.k_gain[4];
                use_root_reg <= (n_reg > NW'(1)) && (m_reg != '0) &&
                                (cfg.k_gain != '0) && (acc_reg != '0);
            end
            S_SQ:
            begin
                pa2_reg <= PA2W'(pa_reg) * PA2W'(pa_reg);
            end
            S_MLO:
            begin
                num_reg <= NUMW'(PLW'(pa2_reg) * PLW'(acc_reg[15:0]));
            end
            S_MHI:
            begin
                num_reg <= num_reg +
                           NUMW'({HIW'(pa2_reg) * HIW'(acc_reg[ACCW-1:16]), 16'h0000});
            end
            S_QWAIT:
            begin
                qrem_reg <= div_rem_nz;
            end
            S_RTWAIT:
            begin
                sq_reg   <= rt_root;
                srem_reg <= rt_rem_nz;
            end
            S_FIN:
            begin
                y_reg <= (YW'(mk_reg) <<< 7) + adj;
            end
            S_OUT:
            begin
                result_reg.threshold     <= (y_reg < 0) ? 8'd0 :
                                            (y_sh > YW'(255)) ? 8'd255 : y_sh[7:0];
                result_reg.is_foreground <= ((y_reg < 0) ? 8'd0 :
                                            (y_sh > YW'(255)) ? 8'd255 : y_sh[7:0]) < pix_reg;
                result_reg.out_row       <= row_reg;
                result_reg.out_col       <= col_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pass_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == S_PASS);
            done_reg     <= (state_reg == S_OUT);
            case (state_reg)
                S_IDLE:
                begin
                    if (pop && (head.kind == KIND_CLASSIFY))
                    begin
                        state_reg <= S_CTR;
                    end
                end
                S_CTR:
                begin
                    pass_reg  <= 1'b0;
                    state_reg <= empty_reg ? S_FIN : S_PASS;
                end
                S_PASS:
                begin
                    if (last_c && last_r)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= pass_reg ? S_PM : S_MDIV;
                end
                S_MDIV:
                begin
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (div_done)
                    begin
                        pass_reg  <= 1'b1;
                        state_reg <= S_PASS;
                    end
                end
                S_PM:
                begin
                    state_reg <= ((n_reg > NW'(1)) && (m_reg != '0) &&
                                  (cfg.k_gain != '0) && (acc_reg != '0)) ? S_SQ : S_FIN;
                end
                S_SQ:     state_reg <= S_MLO;
                S_MLO:    state_reg <= S_MHI;
                S_MHI:    state_reg <= S_QDIV;
                S_QDIV:   state_reg <= S_QWAIT;
                S_QWAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_RT;
                    end
                end
                S_RT:     state_reg <= S_RTWAIT;
                S_RTWAIT:
                begin
                    if (rt_done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:    state_reg <= S_OUT;
                S_OUT:    state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `SLT_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "result strobe held two cycles")
    `SLT_ASSERT(a_write_idle, !ram_we || (state_reg == S_IDLE), "frame write outside idle")

endmodule

FILE: rtl/sauvola_local_threshold_top.sv
// Top level of the Sauvola local threshold block: configuration registers and wiring.
//
// Usage:
//   Command channel: drive cmd and raise start; the word is taken at a rising edge
//   where start is high and busy is low. kind selects a pixel write into the frame
//   store or a classify of the named pixel. Up to four words queue in front of the
//   execution engine; busy rises when that queue is full.
//   Result channel: done is high for one cycle with result holding the threshold,
//   the foreground flag and the echoed position. Results cannot be held off.
//   Writes produce no result and leave the engine idle, free to take the next word.
//   A classify makes two passes over the window through the single frame store
//   port, then a serial divide for the mean, a serial divide of the scaled variance
//   and a serial square root (NUMW = 51, QW = 52 by default); the variance divide
//   and the square root are skipped when the variance term drops out, and all of it
//   is skipped for an empty window.
//   Configuration: cfg_we writes cfg_data into register cfg_index at once; write
//   only while no classify is in flight.
//   Reset clears the queue and the engine and loads the register defaults; the
//   frame store is not cleared and must be written before it is read.
module sauvola_local_threshold_top import slt_pkg::*; #(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  in_t               cmd,
    output logic              busy,
    output logic              done,
    output out_t              result,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic head_valid, pop;
    in_t  head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_cols    <= RST_IMAGE_COLS;
            cfg_reg.image_rows    <= RST_IMAGE_ROWS;
            cfg_reg.window_radius <= RST_WINDOW_RADIUS;
            cfg_reg.k_gain        <= RST_K_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_COLS:    cfg_reg.image_cols    <= cfg_data;
                REG_IMAGE_ROWS:    cfg_reg.image_rows    <= cfg_data[7:0];
                REG_WINDOW_RADIUS: cfg_reg.window_radius <= cfg_data[4:0];
                REG_K_GAIN:        cfg_reg.k_gain        <= cfg_data[4:0];
                default:
                begin
                end
            endcase
        end
    end

    slt_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .busy       (busy),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    slt_back #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .result     (result)
    );

endmodule

FILE: tb/sv/sauvola_local_threshold_checker.sv
// Checker: predicts Sauvola thresholds from observed words and compares results.
`timescale 1ns / 100ps
module sauvola_local_threshold_checker import slt_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  in_t               cmd,
    input  logic              done,
    input  out_t              result,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output int                fail_count,
    output int                pending
);
    logic [7:0]        pix_mem [0:32767];
    logic [8:0]        m_cols;
    logic [7:0]        m_rows;
    logic [4:0]        m_rad;
    logic signed [4:0] m_k;
    out_t              thr_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, t;
        res = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = res | (64'd1 << b);
            if (t * t <= v)
                res = t;
        end
        return res;
    endfunction

    function automatic logic [7:0] local_threshold(int row, int col);
        int rows, cols, rad, r0, r1, c0, c1, kk;
        longint unsigned n, sum, acc, m, d, pa, num, q, sq;
        longint p, y;
        rows = (m_rows > 128) ? 128 : m_rows;
        cols = (m_cols > 256) ? 256 : m_cols;
        rad  = (m_rad > 16) ? 16 : m_rad;
        r0 = (row >= rad) ? row - rad : 0;
        r1 = (row + rad < rows) ? row + rad : rows;
        c0 = (col >= rad) ? col - rad : 0;
        c1 = (col + rad < cols) ? col + rad : cols;
        if (r0 >= r1 || c0 >= c1)
            return 8'd0;
        n = (r1 - r0) * (c1 - c0);
        sum = 0;
        acc = 0;
        for (int r = r0; r < r1; r++)
            for (int c = c0; c < c1; c++)
                sum += pix_mem[r * 256 + c];
        m = sum / n;
        for (int r = r0; r < r1; r++)
            for (int c = c0; c < c1; c++)
            begin
                d = (pix_mem[r * 256 + c] >= m) ? pix_mem[r * 256 + c] - m
                                                 : m - pix_mem[r * 256 + c];
                acc += d * d;
            end
        kk = m_k;
        p = longint'(m) * kk;
        y = 128 * longint'(m) * (1 - kk);
        if (n > 1 && p != 0 && acc != 0)
        begin
            pa  = (p < 0) ? -p : p;
            num = pa * pa * acc;
            q   = num / (n - 1);
            sq  = int_sqrt(q);
            if (p > 0)
                y += longint'(sq);
            else
            begin
                // round the subtracted root up unless exact
                if (sq * sq * (n - 1) != num)
                    sq += 1;
                y -= longint'(sq);
            end
        end
        if (y < 0)
            return 8'd0;
        y = y / 128;
        return (y > 255) ? 8'd255 : 8'(y);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t exp_w;
        if (!rst_n)
        begin
            m_cols = RST_IMAGE_COLS;
            m_rows = RST_IMAGE_ROWS;
            m_rad  = RST_WINDOW_RADIUS;
            m_k    = RST_K_GAIN;
            thr_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (done)
            begin
                if (thr_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_w = thr_q.pop_front();
                    if (result.threshold !== exp_w.threshold)
                    begin
                        $error("threshold expected %0d actual %0d",
                               exp_w.threshold, result.threshold);
                        fail_count++;
                    end
                    if (result.is_foreground !== exp_w.is_foreground)
                    begin
                        $error("is_foreground expected %0d actual %0d",
                               exp_w.is_foreground, result.is_foreground);
                        fail_count++;
                    end
                    if (result.out_row !== exp_w.out_row)
                    begin
                        $error("out_row expected %0d actual %0d",
                               exp_w.out_row, result.out_row);
                        fail_count++;
                    end
                    if (result.out_col !== exp_w.out_col)
                    begin
                        $error("out_col expected %0d actual %0d",
                               exp_w.out_col, result.out_col);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (cmd.kind == KIND_WRITE)
                    pix_mem[cmd.row * 256 + cmd.col] = cmd.pixel_value;
                else
                begin
                    exp_w.threshold     = local_threshold(cmd.row, cmd.col);
                    exp_w.is_foreground = exp_w.threshold < pix_mem[cmd.row * 256 + cmd.col];
                    exp_w.out_row       = cmd.row;
                    exp_w.out_col       = cmd.col;
                    thr_q.insert(thr_q.size(), exp_w);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_COLS:    m_cols = cfg_data[8:0];
                    REG_IMAGE_ROWS:    m_rows = cfg_data[7:0];
                    REG_WINDOW_RADIUS: m_rad  = cfg_data[4:0];
                    REG_K_GAIN:        m_k    = cfg_data[4:0];
                    default: ;
                endcase
            end
            pending = thr_q.size();
        end
    end
endmodule

FILE: tb/sv/tb_sauvola_local_threshold_top.sv
// Testbench top: stimulus, configuration phases, watchdog and verdict.
`timescale 1ns / 100ps
module tb_sauvola_local_threshold_top;
    import slt_pkg::*;

    localparam int WDOG_LIMIT = 40000;

    logic              clk;
    logic              rst_n;
    logic              start;
    in_t               cmd;
    logic              busy;
    logic              done;
    out_t              result;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    int                fail_count;
    int                pending;

    bit                written [0:32767];
    int                cur_cols, cur_rows, cur_rad;
    int                idle_pct;
    int                accept_cnt;
    int                wdog;
    int                n_writes, n_classify, n_done;

    sauvola_local_threshold_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .busy(busy),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sauvola_local_threshold_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            accept_cnt <= accept_cnt + 1;
        if (rst_n && done)
            n_done <= n_done + 1;
        if (!rst_n || (start && !busy) || done)
            wdog <= 0;
        else
            wdog <= wdog + 1;
    end

    always @(posedge clk)
    begin
        if (wdog >= WDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // window and centre pixel must be in written entries only
    function automatic bit window_ok(int row, int col);
        int r0, r1, c0, c1;
        if (!written[row * 256 + col])
            return 0;
        r0 = (row >= cur_rad) ? row - cur_rad : 0;
        r1 = (row + cur_rad < cur_rows) ? row + cur_rad : cur_rows;
        c0 = (col >= cur_rad) ? col - cur_rad : 0;
        c1 = (col + cur_rad < cur_cols) ? col + cur_rad : cur_cols;
        for (int r = r0; r < r1; r++)
            for (int c = c0; c < c1; c++)
                if (!written[r * 256 + c])
                    return 0;
        return 1;
    endfunction

    task automatic send_word(logic kind, int row, int col, int val);
        int cnt0;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        cnt0 = accept_cnt;
        start           <= 1'b1;
        cmd.kind        <= kind;
        cmd.row         <= row[6:0];
        cmd.col         <= col[7:0];
        cmd.pixel_value <= val[7:0];
        do @(negedge clk); while (accept_cnt == cnt0);
        if (kind == KIND_WRITE)
        begin
            written[row * 256 + col] = 1'b1;
            n_writes++;
        end
        else
            n_classify++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        // trailing pixel writes may still sit in the queue
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DW-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_cfg(int cols, int rows, int rad, int k);
        drain();
        write_reg(REG_IMAGE_COLS, cols);
        write_reg(REG_IMAGE_ROWS, rows);
        write_reg(REG_WINDOW_RADIUS, rad);
        write_reg(REG_K_GAIN, k & 31);
        cols = cols & 511;
        rows = rows & 255;
        rad  = rad & 31;
        cur_cols = (cols > 256) ? 256 : cols;
        cur_rows = (rows > 128) ? 128 : rows;
        cur_rad  = (rad > 16) ? 16 : rad;
    endtask

    task automatic write_random();
        int row, col;
        case ($urandom_range(3))
            0, 1: begin row = $urandom_range(9);        col = $urandom_range(9); end
            2:    begin row = $urandom_range(127, 124); col = $urandom_range(255, 252); end
            default: begin row = $urandom_range(127);   col = $urandom_range(255); end
        endcase
        send_word(KIND_WRITE, row, col, $urandom_range(255));
    endtask

    task automatic classify_random();
        int row, col;
        bit ok;
        ok = 0;
        for (int t = 0; t < 20 && !ok; t++)
        begin
            case ($urandom_range(2))
                0: begin row = $urandom_range(9);         col = $urandom_range(9); end
                1: begin row = $urandom_range(127, 124);  col = $urandom_range(255, 252); end
                default: begin row = $urandom_range(127); col = $urandom_range(255); end
            endcase
            ok = window_ok(row, col);
        end
        // fall back to a pixel write when no fully written window turns up
        if (ok)
            send_word(KIND_CLASSIFY, row, col, $urandom_range(255));
        else
            write_random();
    endtask

    initial
    begin
        int phase_pct [0:2];
        int rnd_cols, rnd_rows, rnd_rad;
        phase_pct[0] = 0;
        phase_pct[1] = 63;
        phase_pct[2] = 16;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        accept_cnt = 0;
        n_done     = 0;
        n_writes   = 0;
        n_classify = 0;
        idle_pct   = 0;
        cur_cols   = 256;
        cur_rows   = 128;
        cur_rad    = 8;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill the two corner regions that the test windows mostly draw from
        for (int r = 0; r < 10; r++)
            for (int c = 0; c < 10; c++)
                send_word(KIND_WRITE, r, c, $urandom_range(255));
        for (int r = 124; r < 128; r++)
            for (int c = 252; c < 256; c++)
                send_word(KIND_WRITE, r, c, $urandom_range(255));

        // directed: field extremes and the special windows
        send_word(KIND_WRITE, 0, 0, 255);
        send_word(KIND_WRITE, 0, 1, 0);
        send_word(KIND_WRITE, 127, 255, 255);
        send_word(KIND_WRITE, 125, 253, 0);
        send_word(KIND_CLASSIFY, 0, 0, 0);
        send_word(KIND_CLASSIFY, 1, 1, 0);
        set_cfg(1, 1, 1, 0);                 // one-pixel window
        send_word(KIND_CLASSIFY, 0, 0, 0);
        send_word(KIND_CLASSIFY, 125, 253, 0);   // centre far outside the frame
        set_cfg(256, 128, 2, 8);
        send_word(KIND_CLASSIFY, 5, 5, 0);
        send_word(KIND_CLASSIFY, 126, 254, 0);
        set_cfg(256, 128, 2, -8);
        send_word(KIND_CLASSIFY, 0, 0, 0);
        send_word(KIND_CLASSIFY, 127, 255, 0);
        set_cfg(10, 10, 31, -16);            // radius beyond the limit, clipped
        send_word(KIND_CLASSIFY, 4, 4, 0);
        send_word(KIND_CLASSIFY, 9, 9, 0);
        set_cfg(511, 255, 1, -16);           // frame size beyond the store, clipped
        send_word(KIND_CLASSIFY, 5, 5, 0);
        send_word(KIND_CLASSIFY, 127, 255, 0);
        set_cfg(256, 128, 0, 15);            // empty window
        send_word(KIND_CLASSIFY, 3, 3, 0);
        send_word(KIND_CLASSIFY, 0, 1, 0);
        set_cfg(0, 0, 4, 3);
        send_word(KIND_CLASSIFY, 0, 0, 0);
        set_cfg(10, 10, 16, 15);
        send_word(KIND_CLASSIFY, 9, 0, 0);
        send_word(KIND_CLASSIFY, 127, 255, 0);

        // hold off until every result is in
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_pct = phase_pct[ph % 3];
            if (ph == 5)
                set_cfg(10, 10, 16, 0);
            else
            begin
                rnd_cols = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(1, 12);
                rnd_rows = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(1, 12);
                rnd_rad  = $urandom_range(1) ? $urandom_range(4) : $urandom_range(31);
                set_cfg(rnd_cols, rnd_rows, rnd_rad, $urandom_range(31));
            end
            for (int i = 0; i < 22; i++)
            begin
                if ($urandom_range(1))
                    classify_random();
                else
                    write_random();
            end
        end

        drain();
        repeat (50) @(negedge clk);
        if (pending != 0)
            $error("%0d results never arrived", pending);
        $display("Covered %0d pixel writes and %0d classify words, %0d results checked,",
                 n_writes, n_classify, n_done);
        $display("across clipped, empty, one-pixel and whole-frame windows with k from -16 to 15.");
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
